// ===== sv/plrx_pkg.sv =====
// shared types and constants for the polled uart receive ring device
package plrx_pkg;

  // request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_STAT_RD    = 3'd0,
    REQ_STAT_WR    = 3'd1,
    REQ_RX_RD      = 3'd2,
    REQ_TX_WR      = 3'd3,
    REQ_LINK_BYTE  = 3'd4,
    REQ_CONNECT    = 3'd5,
    REQ_DISCONNECT = 3'd6
  } req_t;

  // status byte bit positions
  localparam int unsigned ST_RX_BIT   = 0;
  localparam int unsigned ST_BUSY_BIT = 1;
  localparam int unsigned ST_RST_BIT  = 2;

  // slot returned by a data read on an empty ring
  localparam int unsigned EMPTY_READ_SLOT = 3;

  // result of one request, before the ring read data is merged in
  typedef struct packed {
    logic       use_mem;
    logic       hit;
    logic [7:0] stat;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } result_t;

endpackage

// ===== sv/plrx_ram.sv =====
// receive ring storage: one write port, one registered read port
module plrx_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/plrx_ctrl.sv =====
// ring pointers, link state and request decode
module plrx_ctrl #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        xfer,
  input  logic [2:0]                  req_type,
  input  logic [7:0]                  data_in,
  output logic                        mem_we,
  output logic [$clog2(RX_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                  mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(RX_DEPTH)-1:0] mem_raddr,
  output plrx_pkg::result_t           result
);

  localparam int unsigned PTR_W      = $clog2(RX_DEPTH);
  localparam int unsigned FILL_W     = $clog2(RX_DEPTH + 1);
  localparam int unsigned EMPTY_SLOT = plrx_pkg::EMPTY_READ_SLOT % RX_DEPTH;

  logic [PTR_W-1:0]  read_ptr, read_ptr_next;
  logic [PTR_W-1:0]  write_ptr, write_ptr_next;
  logic              ring_empty, ring_empty_next;
  logic              link_up, link_up_next;
  // count of ring entries written at least once since reset; entries below it hold real data
  logic [FILL_W-1:0] fill, fill_next;
  logic [PTR_W-1:0]  rp_inc, wp_inc;
  plrx_pkg::req_t    req;

  assign req = plrx_pkg::req_t'(req_type);

  // pointer increments with wrap at the ring depth
  assign rp_inc = (read_ptr == PTR_W'(RX_DEPTH - 1)) ? '0 : read_ptr + 1'b1;
  assign wp_inc = (write_ptr == PTR_W'(RX_DEPTH - 1)) ? '0 : write_ptr + 1'b1;

  // request decode and next state
  always_comb begin
    read_ptr_next   = read_ptr;
    write_ptr_next  = write_ptr;
    ring_empty_next = ring_empty;
    link_up_next    = link_up;
    fill_next       = fill;
    mem_we          = 1'b0;
    mem_waddr       = write_ptr;
    mem_wdata       = data_in;
    mem_re          = 1'b0;
    mem_raddr       = read_ptr;
    result          = '0;
    unique case (req)
      plrx_pkg::REQ_STAT_RD: begin
        result.stat[plrx_pkg::ST_RX_BIT]   = ~ring_empty;
        result.stat[plrx_pkg::ST_BUSY_BIT] = ~link_up;
      end
      plrx_pkg::REQ_STAT_WR: begin
        if (data_in[plrx_pkg::ST_RST_BIT]) begin
          ring_empty_next = 1'b1;
          read_ptr_next   = '0;
          write_ptr_next  = '0;
        end
      end
      plrx_pkg::REQ_RX_RD: begin
        mem_re         = xfer;
        result.use_mem = 1'b1;
        if (ring_empty) begin
          mem_raddr = PTR_W'(EMPTY_SLOT);
        end else begin
          read_ptr_next = rp_inc;
          if (rp_inc == write_ptr) begin
            ring_empty_next = 1'b1;
          end
        end
        result.hit = (FILL_W'(mem_raddr) < fill);
      end
      plrx_pkg::REQ_TX_WR: begin
        if (link_up) begin
          result.tx_valid = 1'b1;
          result.tx_byte  = data_in;
        end
      end
      plrx_pkg::REQ_LINK_BYTE: begin
        mem_we = xfer;
        if (ring_empty) begin
          read_ptr_next   = write_ptr;
          ring_empty_next = 1'b0;
        end
        write_ptr_next = wp_inc;
        if (FILL_W'(write_ptr) == fill) begin
          fill_next = fill + 1'b1;
        end
      end
      plrx_pkg::REQ_CONNECT:    link_up_next = 1'b1;
      plrx_pkg::REQ_DISCONNECT: link_up_next = 1'b0;
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr   <= '0;
      write_ptr  <= '0;
      ring_empty <= 1'b1;
      link_up    <= 1'b0;
      fill       <= '0;
    end else if (xfer) begin
      read_ptr   <= read_ptr_next;
      write_ptr  <= write_ptr_next;
      ring_empty <= ring_empty_next;
      link_up    <= link_up_next;
      fill       <= fill_next;
    end
  end

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (FILL_W'(read_ptr) < FILL_W'(RX_DEPTH)) && (FILL_W'(write_ptr) < FILL_W'(RX_DEPTH)))
    else $error("ring pointer out of range");

  // the write pointer never runs past the written region
  a_wp_fill: assert property (@(posedge clk) disable iff (rst)
    (FILL_W'(write_ptr) <= fill) && (fill <= FILL_W'(RX_DEPTH)))
    else $error("write pointer beyond fill count");

  // a non-empty ring only points at written entries
  a_rp_fill: assert property (@(posedge clk) disable iff (rst)
    !ring_empty |-> (FILL_W'(read_ptr) < fill))
    else $error("read pointer at unwritten entry");

endmodule

// ===== sv/plrx_out.sv =====
// result pipeline: read stage and output register
module plrx_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              xfer,
  input  plrx_pkg::result_t result,
  input  logic [7:0]        mem_rdata,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [7:0]        read_data,
  output logic              tx_valid,
  output logic [7:0]        tx_byte
);

  plrx_pkg::result_t stage;
  logic              stage_valid;
  logic              advance;
  logic [7:0]        stage_rd;

  // stage moves on when the output register is free or being drained
  assign advance   = ~rsp_valid | rsp_ready;
  assign req_ready = ~stage_valid | advance;

  // merge ring read data with status; unwritten entries read as zero
  assign stage_rd = stage.use_mem ? (stage.hit ? mem_rdata : 8'd0) : stage.stat;

  // read stage, aligned with the registered ring read
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (xfer) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (xfer) begin
      stage <= result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
    end
    if (advance && stage_valid) begin
      read_data <= stage_rd;
      tx_valid  <= stage.tx_valid;
      tx_byte   <= stage.tx_byte;
    end
  end

  // a stalled read stage keeps its result
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage)))
    else $error("read stage lost while stalled");

endmodule

// ===== sv/polled_uart_rx_ring_device_core.sv =====
// top level of the polled uart receive ring device
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------
//  request | req_valid / req_ready | req_type, data_in
//  result  | rsp_valid / rsp_ready | read_data, tx_valid, tx_byte
//
// one request a cycle while req_ready is high; each result passes the ring read
// register, then the output register
// reset clears pointers, flags and the fill count; the ring has no clearing
// pass, entries never written since reset read as zero
// two result slots: a stalled result port still takes one more request
module polled_uart_rx_ring_device_core #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [2:0] req_type,
  input  logic [7:0] data_in,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_byte
);

  localparam int unsigned PTR_W = $clog2(RX_DEPTH);

  logic              xfer;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  plrx_pkg::result_t result;

  assign xfer = req_valid & req_ready;

  // request decode and ring state
  plrx_ctrl #(.RX_DEPTH(RX_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .xfer      (xfer),
    .req_type  (req_type),
    .data_in   (data_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .result    (result)
  );

  // receive ring
  plrx_ram #(.DEPTH(RX_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result pipeline
  plrx_out u_out (
    .clk       (clk),
    .rst       (rst),
    .xfer      (xfer),
    .result    (result),
    .mem_rdata (mem_rdata),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .read_data (read_data),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte)
  );

endmodule
